FILE: rtl/spcp_pkg.sv
`default_nettype none

package spcp_pkg;

    localparam int BYTE_W  = 8;
    localparam int PARAM_W = 4;
    localparam int KIND_W  = 2;
    localparam int VAL_W   = 34;
    localparam int FSUM_W  = 10;

    localparam int MAX_VALUE_CHARS_DEF = 7;
    localparam int FRAC_DIGITS_DEF     = 3;

    // output beat layout: param code, value, ring flag, one pad bit
    localparam int M_TDATA_W    = 40;
    localparam int TD_PARAM_LSB = 0;
    localparam int TD_VALUE_LSB = TD_PARAM_LSB + PARAM_W;
    localparam int TD_RING_BIT  = TD_VALUE_LSB + VAL_W;

    localparam logic [VAL_W-1:0] VAL_MAX       = '1;
    localparam logic [VAL_W-1:0] SAT_MILLI     = 34'd65535000;
    localparam logic [VAL_W-1:0] SAT_LIMIT     = 34'd65536000;
    localparam logic [VAL_W-1:0] BUZZ_ON_MILLI = 34'd1000;
    localparam logic [VAL_W-1:0] TEMP_MAX_RST  = 34'd90000;
    localparam logic [VAL_W-1:0] GAIN_LIM_RST  = 34'd100000;

    localparam logic [BYTE_W-1:0] CH_HASH  = "#";
    localparam logic [BYTE_W-1:0] CH_SEMI  = ";";
    localparam logic [BYTE_W-1:0] CH_COMMA = ",";
    localparam logic [BYTE_W-1:0] CH_ZERO  = "0";
    localparam logic [BYTE_W-1:0] CH_NINE  = "9";
    localparam logic [BYTE_W-1:0] CH_GET   = "g";
    localparam logic [BYTE_W-1:0] CH_SET   = "s";
    localparam logic [BYTE_W-1:0] CH_T_LO  = "t";
    localparam logic [BYTE_W-1:0] CH_V     = "v";
    localparam logic [BYTE_W-1:0] CH_B     = "b";
    localparam logic [BYTE_W-1:0] CH_F     = "f";
    localparam logic [BYTE_W-1:0] CH_T_UP  = "T";
    localparam logic [BYTE_W-1:0] CH_P     = "p";
    localparam logic [BYTE_W-1:0] CH_I     = "i";
    localparam logic [BYTE_W-1:0] CH_D     = "d";

    localparam logic [PARAM_W-1:0] P_CUR_TEMP    = 4'd0;
    localparam logic [PARAM_W-1:0] P_COOLER_VEL  = 4'd1;
    localparam logic [PARAM_W-1:0] P_TARGET_TEMP = 4'd2;
    localparam logic [PARAM_W-1:0] P_BUZZ_PLAY   = 4'd3;
    localparam logic [PARAM_W-1:0] P_FREQ        = 4'd4;
    localparam logic [PARAM_W-1:0] P_PERIOD      = 4'd5;
    localparam logic [PARAM_W-1:0] P_KP          = 4'd6;
    localparam logic [PARAM_W-1:0] P_KI          = 4'd7;
    localparam logic [PARAM_W-1:0] P_KD          = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READY,
        ST_GET,
        ST_SET,
        ST_PARAM,
        ST_VALUE
    } t_state;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ,
        KIND_WRITE_OK,
        KIND_MAX_EXCEEDED,
        KIND_OUT_OF_RANGE
    } t_kind;

    typedef enum logic {
        CFG_TEMP_MAX,
        CFG_GAIN_LIMIT
    } t_cfg_idx;

    typedef struct packed {
        t_kind              kind;
        logic [PARAM_W-1:0] param;
        logic [VAL_W-1:0]   value;
        logic               ring;
    } t_result;

    typedef struct packed {
        logic               hit;
        logic [PARAM_W-1:0] code;
    } t_lookup;

    function automatic t_lookup get_code(input logic [BYTE_W-1:0] c);
        t_lookup r;
        r.hit = 1'b1;
        unique case (c)
            CH_T_LO: r.code = P_CUR_TEMP;
            CH_V:    r.code = P_COOLER_VEL;
            CH_F:    r.code = P_FREQ;
            CH_T_UP: r.code = P_PERIOD;
            CH_P:    r.code = P_KP;
            CH_I:    r.code = P_KI;
            CH_D:    r.code = P_KD;
            default: begin
                r.hit  = 1'b0;
                r.code = P_CUR_TEMP;
            end
        endcase
        return r;
    endfunction

    function automatic t_lookup set_code(input logic [BYTE_W-1:0] c);
        t_lookup r;
        r.hit = 1'b1;
        unique case (c)
            CH_T_LO: r.code = P_TARGET_TEMP;
            CH_B:    r.code = P_BUZZ_PLAY;
            CH_F:    r.code = P_FREQ;
            CH_T_UP: r.code = P_PERIOD;
            CH_P:    r.code = P_KP;
            CH_I:    r.code = P_KI;
            CH_D:    r.code = P_KD;
            default: begin
                r.hit  = 1'b0;
                r.code = P_CUR_TEMP;
            end
        endcase
        return r;
    endfunction

    // weight of the n-th fractional digit, in thousandths; nothing past the third
    function automatic logic [FSUM_W-1:0] frac_weight(input int n);
        logic [FSUM_W-1:0] w;
        unique case (n)
            1:       w = 10'd100;
            2:       w = 10'd10;
            3:       w = 10'd1;
            default: w = 10'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/spcp_core.sv
`default_nettype none

module spcp_core
    import spcp_pkg::*;
#(
    parameter int MAX_VALUE_CHARS = MAX_VALUE_CHARS_DEF,
    parameter int FRAC_DIGITS     = FRAC_DIGITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic [VAL_W-1:0]  i_temp_max,
    input  wire logic [VAL_W-1:0]  i_gain_limit,
    output t_result                o_res,
    output logic                   o_res_valid
);

    localparam int CNT_W  = $clog2(MAX_VALUE_CHARS + 1);
    localparam int FRAC_W = (FRAC_DIGITS < 1) ? 1 : $clog2(FRAC_DIGITS + 1);
    localparam int SUM_W  = VAL_W + 4;

    t_state              r_state,  n_state;
    logic [PARAM_W-1:0]  r_param,  n_param;
    logic [CNT_W-1:0]    r_cnt,    n_cnt;
    logic [VAL_W-1:0]    r_accum,  n_accum;
    logic                r_comma,  n_comma;
    logic [FRAC_W-1:0]   r_frac,   n_frac;
    logic [FSUM_W-1:0]   r_fsum,   n_fsum;

    logic [3:0]          digit;
    logic [13:0]         digit_k;
    logic [SUM_W-1:0]    int_sum;
    logic [VAL_W-1:0]    int_next;
    logic [FRAC_W-1:0]   frac_idx;
    logic [FSUM_W-1:0]   frac_add;
    logic [VAL_W:0]      frac_sum;
    logic [VAL_W-1:0]    frac_next;
    logic                is_val_char;
    logic                room;
    t_lookup             get_lu;
    t_lookup             set_lu;
    logic                fin_valid;
    t_result             fin_res;

    // '0'..'9' carry the digit in their low nibble
    assign digit       = i_byte[3:0];
    assign digit_k     = 14'(digit) * 14'd1000;
    assign int_sum     = ({4'b0, r_accum} << 3) + ({4'b0, r_accum} << 1) + SUM_W'(digit_k);
    assign int_next    = (int_sum > SUM_W'(VAL_MAX)) ? VAL_MAX : int_sum[VAL_W-1:0];
    assign frac_idx    = r_frac + FRAC_W'(1);
    assign frac_add    = FSUM_W'(digit) * frac_weight(int'(frac_idx));
    assign frac_sum    = {1'b0, r_accum} + (VAL_W+1)'(frac_add);
    assign frac_next   = frac_sum[VAL_W] ? VAL_MAX : frac_sum[VAL_W-1:0];
    assign is_val_char = ((i_byte >= CH_ZERO) && (i_byte <= CH_NINE)) || (i_byte == CH_COMMA);
    assign room        = r_cnt < CNT_W'(MAX_VALUE_CHARS);
    assign get_lu      = get_code(i_byte);
    assign set_lu      = set_code(i_byte);

    // closing checks of a set command; r_fsum is the sub-unit part unless saturated
    always_comb begin
        fin_res       = '0;
        fin_res.param = r_param;
        fin_res.value = r_accum;
        fin_valid     = 1'b1;
        unique case (r_param)
            P_TARGET_TEMP: begin
                fin_res.kind = (r_accum > i_temp_max) ? KIND_MAX_EXCEEDED : KIND_WRITE_OK;
            end
            P_BUZZ_PLAY: begin
                fin_res.kind = (r_accum != BUZZ_ON_MILLI) ? KIND_OUT_OF_RANGE : KIND_WRITE_OK;
            end
            P_FREQ, P_PERIOD: begin
                fin_res.kind  = KIND_WRITE_OK;
                fin_res.value = (r_accum >= SAT_LIMIT) ? SAT_MILLI
                                                       : r_accum - VAL_W'(r_fsum);
            end
            P_KP, P_KI, P_KD: begin
                fin_res.kind = (r_accum >= i_gain_limit) ? KIND_OUT_OF_RANGE : KIND_WRITE_OK;
            end
            default: begin
                fin_valid = 1'b0;
            end
        endcase
        fin_res.ring = (fin_res.kind == KIND_WRITE_OK);
    end

    always_comb begin
        n_state     = r_state;
        n_param     = r_param;
        n_cnt       = r_cnt;
        n_accum     = r_accum;
        n_comma     = r_comma;
        n_frac      = r_frac;
        n_fsum      = r_fsum;
        o_res       = '0;
        o_res.param = r_param;
        o_res_valid = 1'b0;
        if (i_valid) begin
            if (i_byte == CH_HASH) begin
                n_state = ST_READY;
                n_cnt   = '0;
                n_accum = '0;
                n_comma = 1'b0;
                n_frac  = '0;
                n_fsum  = '0;
            end else begin
                unique case (r_state)
                    ST_IDLE: begin
                        n_state = ST_IDLE;
                    end
                    ST_READY: begin
                        priority if (i_byte == CH_GET) begin
                            n_state = ST_GET;
                        end else if (i_byte == CH_SET) begin
                            n_state = ST_SET;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                    ST_GET: begin
                        n_state = get_lu.hit ? ST_PARAM : ST_IDLE;
                        if (get_lu.hit) begin
                            n_param = get_lu.code;
                        end
                    end
                    ST_SET: begin
                        n_state = set_lu.hit ? ST_VALUE : ST_IDLE;
                        if (set_lu.hit) begin
                            n_param = set_lu.code;
                            n_cnt   = '0;
                            n_accum = '0;
                            n_comma = 1'b0;
                            n_frac  = '0;
                            n_fsum  = '0;
                        end
                    end
                    ST_PARAM: begin
                        n_state = ST_IDLE;
                        if (i_byte == CH_SEMI) begin
                            o_res.kind  = KIND_READ;
                            o_res_valid = 1'b1;
                        end
                    end
                    ST_VALUE: begin
                        if (is_val_char && room) begin
                            n_cnt = r_cnt + CNT_W'(1);
                            priority if (i_byte == CH_COMMA) begin
                                n_comma = 1'b1;
                            end else if (!r_comma) begin
                                n_accum = int_next;
                            end else if (r_frac < FRAC_W'(FRAC_DIGITS)) begin
                                n_frac  = frac_idx;
                                n_accum = frac_next;
                                n_fsum  = r_fsum + frac_add;
                            end else begin
                                n_accum = r_accum;
                            end
                        end else begin
                            if (i_byte == CH_SEMI) begin
                                o_res       = fin_res;
                                o_res_valid = fin_valid;
                            end
                            n_state = ST_IDLE;
                            n_cnt   = '0;
                            n_accum = '0;
                            n_comma = 1'b0;
                            n_frac  = '0;
                            n_fsum  = '0;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_param <= '0;
            r_cnt   <= '0;
            r_accum <= '0;
            r_comma <= 1'b0;
            r_frac  <= '0;
            r_fsum  <= '0;
        end else begin
            r_state <= n_state;
            r_param <= n_param;
            r_cnt   <= n_cnt;
            r_accum <= n_accum;
            r_comma <= n_comma;
            r_frac  <= n_frac;
            r_fsum  <= n_fsum;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/spcp_outbuf.sv
`default_nettype none

module spcp_outbuf
    import spcp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_ready,
    output logic         o_valid,
    output t_result      o_data,
    input  wire logic    i_ready
);

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // the skid slot is empty whenever a push can arrive
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/serial_param_command_parser.sv
// Channel  Dir  Beat fields (low bit first)
// s_axis   in   tdata: rx_byte[7:0]
// m_axis   out  tdata: param_code[3:0], value_milli[37:4], ring_buzzer[38], pad[39]
//               tuser: result_kind[1:0]
// cfg      in   index: 0 temp_target_max_milli, 1 gain_limit_milli; data 34 bits
//
// One byte per cycle while s_axis_tready is high; each result beat is registered.
// Parser state updates in the accept cycle, so throughput is set by the output
// register plus one skid entry: s_axis_tready drops only while both hold results.
// Synchronous active-low reset clears the parser to idle and config to defaults.
// cfg writes are always accepted.
`default_nettype none

module serial_param_command_parser
    import spcp_pkg::*;
#(
    parameter int MAX_VALUE_CHARS = MAX_VALUE_CHARS_DEF,
    parameter int FRAC_DIGITS     = FRAC_DIGITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [BYTE_W-1:0]    s_axis_tdata,   // rx_byte
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata,   // param_code, value_milli, ring_buzzer
    output logic [KIND_W-1:0]         m_axis_tuser,   // result_kind
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic                 i_cfg_index,
    input  wire logic [VAL_W-1:0]     i_cfg_data
);

    logic [VAL_W-1:0] r_temp_max;
    logic [VAL_W-1:0] r_gain_limit;
    logic             accept;
    logic             res_valid;
    t_result          res;
    t_result          out_res;

    assign o_cfg_ready = 1'b1;
    assign accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_max   <= TEMP_MAX_RST;
            r_gain_limit <= GAIN_LIM_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TEMP_MAX:   r_temp_max   <= i_cfg_data;
                CFG_GAIN_LIMIT: r_gain_limit <= i_cfg_data;
                default:        r_temp_max   <= r_temp_max;
            endcase
        end
    end

    spcp_core #(
        .MAX_VALUE_CHARS (MAX_VALUE_CHARS),
        .FRAC_DIGITS     (FRAC_DIGITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (accept),
        .i_byte       (s_axis_tdata),
        .i_temp_max   (r_temp_max),
        .i_gain_limit (r_gain_limit),
        .o_res        (res),
        .o_res_valid  (res_valid)
    );

    spcp_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (out_res),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {1'b0, out_res.ring, out_res.value, out_res.param};
    assign m_axis_tuser = out_res.kind;

endmodule

`default_nettype wire

FILE: rtl/spcp_checker.sv
`default_nettype none

module spcp_checker
    import spcp_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 s_axis_tready,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic [KIND_W-1:0]    m_axis_tuser
);

    // hold a stalled result beat
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_ring_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[TD_RING_BIT] == (m_axis_tuser == KIND_W'(KIND_WRITE_OK))))
        else $error("ring flag disagrees with result kind");

    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_W'(KIND_READ)) |->
            (m_axis_tdata[TD_RING_BIT-1:TD_VALUE_LSB] == '0))
        else $error("read request carries a value");

    // input backpressure only while a result waits in front of it
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

endmodule

bind serial_param_command_parser spcp_checker u_spcp_checker (.*);

`default_nettype wire
